FILE: sv/bld_pkg.sv
// Shared types and codes for the bounded deque engine.
// No dependencies; imported by bld_cell, bounded_list_deque_engine and the testbench.
`default_nettype none

package bld_pkg;

	// Index width that covers every cell position up to the largest supported depth (256)
	localparam int IDX_W = 9;
	localparam int VAL_W = 32;

	typedef enum logic [2:0] {
		CMD_SEED     = 3'd0,
		CMD_APPEND   = 3'd1,
		CMD_PREPEND  = 3'd2,
		CMD_POP_HEAD = 3'd3,
		CMD_POP_TAIL = 3'd4,
		CMD_POP_IDX  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Per-cycle action broadcast along the cell row
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SEED,
		CELL_APPEND,
		CELL_PREPEND,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 op;
		logic [IDX_W-1:0]         tgt;     // append slot or removal point
		logic [IDX_W-1:0]         rd_idx;  // cell whose value is read out
		logic signed [VAL_W-1:0]  value;   // value to load
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/bld_cell.sv
// One storage cell of the deque row: holds one value, shifts to either neighbour.
// Depends on bld_pkg.
`default_nettype none

module bld_cell
	import bld_pkg::*;
#(
	parameter int INDEX = 0
) (
	input  wire logic                    clk,
	input  var  cell_ctrl_t              ctrl,
	input  wire logic signed [VAL_W-1:0] left_val,   // value of cell INDEX-1
	input  wire logic signed [VAL_W-1:0] right_val,  // value of cell INDEX+1
	output logic signed [VAL_W-1:0]      val_q,
	output logic signed [VAL_W-1:0]      rd_data     // val_q when selected, else zero
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic signed [VAL_W-1:0] val_d;

	always_comb begin
		val_d = val_q;
		case (ctrl.op)
			CELL_SEED: begin
				if (MY_IDX == '0) val_d = ctrl.value;
			end
			CELL_APPEND: begin
				if (MY_IDX == ctrl.tgt) val_d = ctrl.value;
			end
			CELL_PREPEND: begin
				if (MY_IDX == '0) val_d = ctrl.value;
				else              val_d = left_val;
			end
			CELL_REMOVE: begin
				// cells past the tail take junk; they are never read
				if (MY_IDX >= ctrl.tgt) val_d = right_val;
			end
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign rd_data = (MY_IDX == ctrl.rd_idx) ? val_q : '0;

endmodule

`default_nettype wire

FILE: sv/bounded_list_deque_engine.sv
// Bounded deque engine: top level with command decode, occupancy and result register.
// Depends on bld_pkg and bld_cell.
//
// Usage:
//   Commands arrive on the s_axis request channel: tuser carries the command
//   code, tdata the value and the pop position. Each accepted request yields
//   exactly one result on m_axis: tdata holds the removed value and the new
//   element count, tuser the status (ok, empty, full, index out of range).
//   Storage is a row of DEPTH cells; slot 0 is the head. Every command moves
//   all cells at once (load, shift towards head, shift towards tail or hold),
//   each cell deciding from its own index against the broadcast target.
//   Latency: the result is on m_axis the cycle after the request is taken.
//   Throughput: one request per cycle while m_axis_tready is high; the single
//   result register is the only buffer, so s_axis_tready is high whenever that
//   register is empty or is being drained in the same cycle.
//   Stall: while m_axis_tready is low and a result waits, s_axis_tready drops
//   and the store does not move.
//   Reset: arst_n clears the element count and the result valid flag; cell
//   contents are left as they are and are only read once written.
//   Failed commands leave the store untouched; pop results on failure are zero.
`default_nettype none

module bounded_list_deque_engine
	import bld_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,   // [31:0] value_in, [35:32] position, rest zero
	input  wire logic [2:0]  s_axis_tuser,   // [2:0] command
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [31:0] value_out, [36:32] count, rest zero
	output logic [1:0]       m_axis_tuser    // [1:0] status
);

	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);
	localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

	// request fields
	logic signed [VAL_W-1:0] value_in;
	logic [3:0]              position;
	cmd_t                    command;

	assign value_in = s_axis_tdata[31:0];
	assign position = s_axis_tdata[35:32];
	assign command  = cmd_t'(s_axis_tuser);

	logic                    accept;
	logic [OCC_W-1:0]        occ_q, occ_d;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] value_out_q;
	logic [4:0]              count_q;
	status_t                 status_q;

	cell_ctrl_t              ctrl;
	status_t                 status_d;
	logic                    take_value;
	logic signed [VAL_W-1:0] cell_val [DEPTH];
	logic signed [VAL_W-1:0] cell_rd  [DEPTH];
	logic signed [VAL_W-1:0] rd_value;
	logic [IDX_W-1:0]        occ_ext, pos_ext;
	logic                    is_empty, is_full;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign occ_ext  = IDX_W'(occ_q);
	assign pos_ext  = IDX_W'(position);
	assign is_empty = (occ_q == '0);
	assign is_full  = (occ_q >= OCC_FULL);

	// Command decode: cell action, read point, status and next count
	always_comb begin
		ctrl.op     = CELL_HOLD;
		ctrl.tgt    = occ_ext;
		ctrl.rd_idx = '0;
		ctrl.value  = value_in;
		status_d    = ST_OK;
		take_value  = 1'b0;
		occ_d       = occ_q;
		case (command)
			CMD_SEED: begin
				ctrl.op = CELL_SEED;
				occ_d   = OCC_ONE;
			end
			CMD_APPEND: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.op = CELL_APPEND;
					occ_d   = occ_q + OCC_ONE;
				end
			end
			CMD_PREPEND: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.op = CELL_PREPEND;
					occ_d   = occ_q + OCC_ONE;
				end
			end
			CMD_POP_HEAD: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					ctrl.op    = CELL_REMOVE;
					ctrl.tgt   = '0;
					take_value = 1'b1;
					occ_d      = occ_q - OCC_ONE;
				end
			end
			CMD_POP_TAIL: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					// tail cell simply falls out of the occupied range
					ctrl.rd_idx = occ_ext - IDX_W'(1);
					take_value  = 1'b1;
					occ_d       = occ_q - OCC_ONE;
				end
			end
			CMD_POP_IDX: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else if (pos_ext >= occ_ext) begin
					status_d = ST_RANGE;
				end else begin
					ctrl.op     = CELL_REMOVE;
					ctrl.tgt    = pos_ext;
					ctrl.rd_idx = pos_ext;
					take_value  = 1'b1;
					occ_d       = occ_q - OCC_ONE;
				end
			end
			default: ; // unused codes: no change
		endcase
		if (!accept) ctrl.op = CELL_HOLD;
	end

	// Cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_v, right_v;
		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_val[i+1];
		end

		bld_cell #(
			.INDEX(i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.left_val (left_v),
			.right_val(right_v),
			.val_q    (cell_val[i]),
			.rd_data  (cell_rd[i])
		);
	end

	// Only the selected cell drives a non-zero read value
	always_comb begin
		rd_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_value = rd_value | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				occ_q <= occ_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_out_q <= take_value ? rd_value : '0;
			status_q    <= status_d;
			count_q     <= 5'(occ_d);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, count_q, value_out_q};
	assign m_axis_tuser  = status_q;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for bounded_list_deque_engine: directed and random requests.
// Depends on bld_pkg and the engine RTL; runs a deque predictor alongside the block.
`timescale 1ns / 100ps

module tb;
	import bld_pkg::*;

	localparam int DEPTH    = 16;
	localparam int LATENCY  = 4;
	// Command codes the block leaves unused
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

	typedef struct {
		logic signed [31:0] value;
		status_t            status;
		logic [4:0]         count;
	} deque_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // [31:0] value_in, [35:32] position, rest zero
	logic [2:0]  s_axis_tuser;   // [2:0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // [31:0] value_out, [36:32] count, rest zero
	logic [1:0]  m_axis_tuser;   // [1:0] status

	logic signed [31:0] deque_model[$];   // predicted contents, head first
	deque_result_t      pending_results[$];
	int                 mismatches;
	bit                 quiet;            // no idling on either side

	bounded_list_deque_engine #(.DEPTH(DEPTH)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// Apply one request to the predicted deque and return what the block should report
	function automatic deque_result_t deque_predict(input logic [2:0] cmd,
			input logic signed [31:0] val, input logic [3:0] pos);
		deque_result_t r;
		r.value  = '0;
		r.status = ST_OK;
		case (cmd)
			CMD_SEED: begin
				deque_model.delete();
				deque_model.push_back(val);
			end
			CMD_APPEND: begin
				if (deque_model.size() >= DEPTH) r.status = ST_FULL;
				else deque_model.push_back(val);
			end
			CMD_PREPEND: begin
				if (deque_model.size() >= DEPTH) r.status = ST_FULL;
				else deque_model.push_front(val);
			end
			CMD_POP_HEAD: begin
				if (deque_model.size() == 0) r.status = ST_EMPTY;
				else r.value = deque_model.pop_front();
			end
			CMD_POP_TAIL: begin
				if (deque_model.size() == 0) r.status = ST_EMPTY;
				else r.value = deque_model.pop_back();
			end
			CMD_POP_IDX: begin
				if (deque_model.size() == 0) begin
					r.status = ST_EMPTY;
				end else if (pos >= deque_model.size()) begin
					r.status = ST_RANGE;
				end else begin
					r.value = deque_model[pos];
					deque_model.delete(pos);
				end
			end
			default: ;
		endcase
		r.count = 5'(deque_model.size());
		return r;
	endfunction

	// Drive one request from a falling edge; returns at the falling edge after it is taken
	task automatic send_request(input logic [2:0] cmd, input logic signed [31:0] val,
			input logic [3:0] pos);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, pos, val};
		s_axis_tuser  <= cmd;
		forever begin
			@(posedge clk);
			if (s_axis_tready) break;
		end
		pending_results.push_back(deque_predict(cmd, val, pos));
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return VAL_MAX;
			1:       return VAL_MIN;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Pops on an empty store, spare codes, reseeding and a single-element tail pop
	task automatic test_edge_cases();
		send_request(CMD_POP_HEAD, '0, 4'd0);
		send_request(CMD_POP_TAIL, '0, 4'd0);
		send_request(CMD_POP_IDX,  '0, 4'd15);
		send_request(CMD_SPARE6,   VAL_MAX, 4'd15);
		send_request(CMD_SEED,     VAL_MAX, 4'd0);
		send_request(CMD_POP_TAIL, '0, 4'd0);
		send_request(CMD_SEED,     VAL_MIN, 4'd0);
		send_request(CMD_APPEND,   -32'sd1, 4'd0);
		send_request(CMD_PREPEND,  '0, 4'd0);
		send_request(CMD_POP_IDX,  '0, 4'd3);   // one past the end
		send_request(CMD_POP_IDX,  '0, 4'd1);
		send_request(CMD_SPARE7,   -32'sd1, 4'd9);
		send_request(CMD_SEED,     32'sd12345, 4'd0);
		send_request(CMD_POP_HEAD, '0, 4'd0);
	endtask

	// Fill to DEPTH from both ends, push against a full store, then pop by position at both ends and pop the head
	task automatic test_capacity();
		send_request(CMD_SEED, $urandom, 4'd0);
		while (deque_model.size() < DEPTH)
			send_request(deque_model.size() % 2 ? CMD_PREPEND : CMD_APPEND, pick_value(), 4'd0);
		send_request(CMD_APPEND,   VAL_MAX, 4'd0);
		send_request(CMD_PREPEND,  VAL_MIN, 4'd0);
		send_request(CMD_POP_IDX,  '0, 4'd15);
		send_request(CMD_POP_IDX,  '0, 4'd0);
		send_request(CMD_POP_IDX,  '0, 4'd13);
		send_request(CMD_POP_HEAD, '0, 4'd0);
	endtask

	// Random traffic in modes that grow, drain or churn the store, plus some noise
	task automatic test_random_traffic(input int n_requests);
		int          mode;
		int          left_in_mode;
		int          occ;
		int          roll;
		logic [2:0]  cmd;
		logic [3:0]  pos;
		left_in_mode = 0;
		mode = 0;
		repeat (n_requests) begin
			if (left_in_mode == 0) begin
				mode = $urandom_range(0, 3);
				left_in_mode = $urandom_range(8, 24);
			end
			left_in_mode--;
			occ  = deque_model.size();
			roll = $urandom_range(0, 99);
			case (mode)
				0:       cmd = roll < 75 ? ($urandom_range(0, 1) ? CMD_APPEND : CMD_PREPEND)
						: 3'($urandom_range(CMD_POP_HEAD, CMD_POP_IDX));
				1:       cmd = roll < 75 ? 3'($urandom_range(CMD_POP_HEAD, CMD_POP_IDX))
						: ($urandom_range(0, 1) ? CMD_APPEND : CMD_PREPEND);
				2:       cmd = roll < 4 ? CMD_SEED : 3'($urandom_range(CMD_APPEND, CMD_POP_IDX));
				default: cmd = 3'($urandom_range(0, 7));
			endcase
			if (mode != 3 && occ > 0 && $urandom_range(0, 99) < 85)
				pos = 4'($urandom_range(0, occ > 16 ? 15 : occ - 1));
			else
				pos = 4'($urandom_range(0, 15));
			send_request(cmd, pick_value(), pos);
		end
	endtask

	// Result side: random stall bursts, none once the run goes quiet
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	end

	// Compare each taken result with the oldest prediction
	always @(posedge clk) begin
		deque_result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result value=%h status=%0d count=%0d", $realtime,
						m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[36:32]);
			end else begin
				exp_r = pending_results.pop_front();
				if (m_axis_tdata[31:0] !== exp_r.value || m_axis_tuser !== exp_r.status ||
						m_axis_tdata[36:32] !== exp_r.count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch value %h/%h status %0d/%0d count %0d/%0d (exp/act)",
							$realtime, exp_r.value, m_axis_tdata[31:0], exp_r.status,
							m_axis_tuser, exp_r.count, m_axis_tdata[36:32]);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		mismatches    = 0;
		quiet         = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_edge_cases();
		test_capacity();
		test_random_traffic(1500);
		quiet = 1'b1;
		test_random_traffic(430);
		s_axis_tvalid <= 1'b0;

		// drain, bounded so a hung result path still ends the run
		repeat (1000) begin
			if (pending_results.size() == 0) break;
			@(posedge clk);
		end
		repeat (LATENCY) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
sv/bld_pkg.sv
sv/bld_cell.sv
sv/bounded_list_deque_engine.sv
tb/tb.sv
